### hw/rtl/compton_cone_builder_core_macros.svh
// Assertion macros for the Compton cone builder checker.
// Included by files that hold concurrent assertions; depends on nothing.
`ifndef COMPTON_CONE_BUILDER_CORE_MACROS_SVH
`define COMPTON_CONE_BUILDER_CORE_MACROS_SVH

// Antecedent and consequent are checked at the same clock edge.
`define CCB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cone builder assertion failed");

// The consequent is checked at the clock edge after the antecedent.
`define CCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cone builder assertion failed");

`endif

### hw/rtl/ccb_pkg.sv
// Shared widths, constants and types of the Compton cone builder.
// Used by the channel interfaces and the core; depends on nothing.
package ccb_pkg;

  localparam int HIST_W   = 32;
  localparam int ENERGY_W = 24;
  localparam int POS_W    = 16;
  localparam int AXIS_W   = 17;
  localparam int COS_W    = 17;
  localparam int PROD_W   = 2 * ENERGY_W;
  localparam int NUM_W    = 40;
  localparam int QUOT_W   = 17;
  localparam int CNT_W    = 5;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = ENERGY_W;

  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_ENERGY   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_WINDOW = 2'd1;

  localparam logic [ENERGY_W-1:0] PEAK_RESET    = 24'd43319;
  localparam logic [ENERGY_W-1:0] WINDOW_RESET  = 24'd3277;
  localparam logic [ENERGY_W-1:0] ELECTRON_MASS = 24'd33489;

  localparam logic [CNT_W-1:0] DIV_TOP = 5'd16;
  localparam logic [QUOT_W:0]  Q16_ONE = 18'h10000;

  localparam logic [1:0] COUNT_NONE = 2'd0;
  localparam logic [1:0] COUNT_ONE  = 2'd1;
  localparam logic [1:0] COUNT_MANY = 2'd2;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PREP    = 7'b0000010,
    S_MUL_DEN = 7'b0000100,
    S_MUL_NUM = 7'b0001000,
    S_CHECK   = 7'b0010000,
    S_DIV     = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

endpackage

### hw/rtl/ccb_pulse_if.sv
// Input channel of the Compton cone builder: one detector pulse per transfer.
// Depends on ccb_pkg for the field widths.
interface ccb_pulse_if;
  import ccb_pkg::*;

  logic                valid;
  logic                ready;
  logic [HIST_W-1:0]   history;
  logic [ENERGY_W-1:0] initial_energy;
  logic [ENERGY_W-1:0] pulse_height;
  pos_t                pos_x;
  pos_t                pos_y;
  pos_t                pos_z;

  modport source (
    output valid, history, initial_energy, pulse_height, pos_x, pos_y, pos_z,
    input  ready
  );

  modport sink (
    input  valid, history, initial_energy, pulse_height, pos_x, pos_y, pos_z,
    output ready
  );

endinterface

### hw/rtl/ccb_cone_if.sv
// Output channel of the Compton cone builder: one reconstructed cone per transfer.
// Depends on ccb_pkg for the field widths.
interface ccb_cone_if;
  import ccb_pkg::*;

  logic                    valid;
  logic                    ready;
  pos_t                    apex_x;
  pos_t                    apex_y;
  pos_t                    apex_z;
  axis_t                   axis_x;
  axis_t                   axis_y;
  axis_t                   axis_z;
  logic signed [COS_W-1:0] cos_half_angle;
  logic [ENERGY_W-1:0]     total_energy;
  logic [ENERGY_W-1:0]     deposited_energy;
  logic [HIST_W-1:0]       cone_history;

  modport source (
    output valid, apex_x, apex_y, apex_z, axis_x, axis_y, axis_z, cos_half_angle,
           total_energy, deposited_energy, cone_history,
    input  ready
  );

  modport sink (
    input  valid, apex_x, apex_y, apex_z, axis_x, axis_y, axis_z, cos_half_angle,
           total_energy, deposited_energy, cone_history,
    output ready
  );

endinterface

### hw/rtl/compton_cone_builder_core.sv
// Compton cone builder top level: pulse grouping, cone judgment and output register.
// Depends on ccb_pkg, ccb_pulse_if and ccb_cone_if.
//
// A pulse that joins the open group, or opens the first group, is taken and the
// block stays ready for further pulses. A pulse with a new history closes the
// open group, and the block is then busy through these steps in order: checks,
// the shared 24 by 24 multiplier for the denominator and then the numerator,
// a range check, the restoring divider that yields one quotient bit per cycle,
// then the load of the output register. A group rejected by the checks frees
// the block after the range check. If the previous cone has not been taken yet,
// the block waits in the last step until it is.
// The last open group is only judged when a pulse of another history arrives.
module compton_cone_builder_core (
  input  logic                            clk,
  input  logic                            rst,
  ccb_pulse_if.sink                       pulse_in,
  ccb_cone_if.source                      cone_out,
  input  logic                            cfg_we,
  input  logic [ccb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ccb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ccb_pkg::*;

  state_t state;

  logic [ENERGY_W-1:0] peak_energy;
  logic [ENERGY_W-1:0] energy_window;

  logic [HIST_W-1:0]   open_history;
  logic [1:0]          group_count;
  logic [ENERGY_W-1:0] first_energy;
  logic [ENERGY_W-1:0] first_height;
  pos_t                first_pos [3];
  logic [ENERGY_W-1:0] second_energy;
  pos_t                second_pos [3];

  logic [HIST_W-1:0]   j_history;
  logic                j_many;
  logic [ENERGY_W-1:0] j_energy;
  logic [ENERGY_W-1:0] j_height;
  pos_t                j_first [3];
  pos_t                j_second [3];
  axis_t               j_axis [3];
  logic [ENERGY_W-1:0] j_diff;
  logic                j_ok;

  logic [PROD_W-1:0]   den;
  logic [NUM_W-1:0]    num;
  logic                num_lt_den;
  logic [PROD_W:0]     rem;
  logic [QUOT_W-1:0]   quot;
  logic [CNT_W-1:0]    div_cnt;

  logic                accept;
  logic                new_group;
  logic                judge_start;
  logic [ENERGY_W-1:0] dev;
  axis_t               axis_now [3];
  logic [ENERGY_W-1:0] mult_a;
  logic [ENERGY_W-1:0] mult_b;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     trial;
  logic                trial_ge;
  logic                round_up;
  logic [QUOT_W:0]     quot_rounded;
  logic                out_free;

  assign pulse_in.ready = (state == S_IDLE);
  assign accept         = pulse_in.valid && pulse_in.ready;
  assign new_group      = (group_count == COUNT_NONE) || (pulse_in.history != open_history);
  assign judge_start    = accept && (group_count != COUNT_NONE)
                          && (pulse_in.history != open_history);
  assign out_free       = !cone_out.valid || cone_out.ready;

  always_comb begin
    dev = (j_energy >= peak_energy) ? (j_energy - peak_energy) : (peak_energy - j_energy);
    for (int i = 0; i < 3; i++) begin
      axis_now[i] = axis_t'(j_second[i]) - axis_t'(j_first[i]);
    end
  end

  assign mult_a = (state == S_MUL_DEN) ? j_diff : j_height;
  assign mult_b = (state == S_MUL_DEN) ? j_energy : ELECTRON_MASS;
  assign prod   = PROD_W'(mult_a) * PROD_W'(mult_b);

  assign trial    = (div_cnt == DIV_TOP) ? rem : {rem[PROD_W-1:0], 1'b0};
  assign trial_ge = trial >= {1'b0, den};

  assign round_up     = num_lt_den && (rem != '0);
  assign quot_rounded = {1'b0, quot} + {{QUOT_W{1'b0}}, round_up};

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_energy   <= PEAK_RESET;
      energy_window <= WINDOW_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_PEAK_ENERGY) begin
        peak_energy <= cfg_data;
      end else if (cfg_index == REG_ENERGY_WINDOW) begin
        energy_window <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count   <= COUNT_NONE;
      open_history  <= '0;
      first_energy  <= '0;
      first_height  <= '0;
      first_pos     <= '{default: '0};
      second_energy <= '0;
      second_pos    <= '{default: '0};
    end else if (accept) begin
      open_history <= pulse_in.history;
      if (new_group) begin
        group_count  <= COUNT_ONE;
        first_energy <= pulse_in.initial_energy;
        first_height <= pulse_in.pulse_height;
        first_pos[0] <= pulse_in.pos_x;
        first_pos[1] <= pulse_in.pos_y;
        first_pos[2] <= pulse_in.pos_z;
      end else begin
        group_count <= COUNT_MANY;
        if (pulse_in.initial_energy > first_energy) begin
          second_energy <= first_energy;
          second_pos    <= first_pos;
          first_energy  <= pulse_in.initial_energy;
          first_height  <= pulse_in.pulse_height;
          first_pos[0]  <= pulse_in.pos_x;
          first_pos[1]  <= pulse_in.pos_y;
          first_pos[2]  <= pulse_in.pos_z;
        end else if ((group_count == COUNT_ONE)
                     || (pulse_in.initial_energy > second_energy)) begin
          second_energy <= pulse_in.initial_energy;
          second_pos[0] <= pulse_in.pos_x;
          second_pos[1] <= pulse_in.pos_y;
          second_pos[2] <= pulse_in.pos_z;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cone_out.valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      cone_out.valid <= 1'b1;
    end else if (cone_out.ready) begin
      cone_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (judge_start) begin
            j_history <= open_history;
            j_many    <= (group_count == COUNT_MANY);
            j_energy  <= first_energy;
            j_height  <= first_height;
            j_first   <= first_pos;
            j_second  <= second_pos;
            state     <= S_PREP;
          end
        end
        S_PREP: begin
          j_diff <= j_energy - j_height;
          j_axis <= axis_now;
          j_ok   <= j_many && (dev <= energy_window) && (j_height != '0)
                    && (j_energy > j_height)
                    && ((axis_now[0] != '0) || (axis_now[1] != '0) || (axis_now[2] != '0));
          state  <= S_MUL_DEN;
        end
        S_MUL_DEN: begin
          den   <= prod;
          state <= S_MUL_NUM;
        end
        S_MUL_NUM: begin
          num   <= prod[NUM_W-1:0];
          state <= S_CHECK;
        end
        S_CHECK: begin
          num_lt_den <= {{(PROD_W-NUM_W){1'b0}}, num} < den;
          rem        <= {{(PROD_W+1-NUM_W){1'b0}}, num};
          quot       <= '0;
          div_cnt    <= DIV_TOP;
          if (j_ok && ({{(PROD_W+1-NUM_W){1'b0}}, num} < {den, 1'b0})) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          rem  <= trial_ge ? (trial - {1'b0, den}) : trial;
          quot <= {quot[QUOT_W-2:0], trial_ge};
          if (div_cnt == '0) begin
            state <= S_EMIT;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            cone_out.apex_x           <= j_first[0];
            cone_out.apex_y           <= j_first[1];
            cone_out.apex_z           <= j_first[2];
            cone_out.axis_x           <= j_axis[0];
            cone_out.axis_y           <= j_axis[1];
            cone_out.axis_z           <= j_axis[2];
            cone_out.cos_half_angle   <= COS_W'(Q16_ONE - quot_rounded);
            cone_out.total_energy     <= j_energy;
            cone_out.deposited_energy <= j_height;
            cone_out.cone_history     <= j_history;
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/ccb_checker.sv
// Port-level checker for the Compton cone builder, bound to the top level.
// Depends on ccb_pkg and the assertion macros header.
`include "compton_cone_builder_core_macros.svh"

module ccb_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ccb_pkg::AXIS_W-1:0]    axis_x,
  input logic signed [ccb_pkg::AXIS_W-1:0]    axis_y,
  input logic signed [ccb_pkg::AXIS_W-1:0]    axis_z,
  input logic signed [ccb_pkg::COS_W-1:0]     cos_half_angle,
  input logic [ccb_pkg::ENERGY_W-1:0]         total_energy,
  input logic [ccb_pkg::ENERGY_W-1:0]         deposited_energy
);
  import ccb_pkg::*;

  localparam logic signed [COS_W-1:0] COS_MINUS_ONE = 17'h10000;

  // A new cone only appears after the block has been busy judging a group.
  `CCB_ASSERT_SAME(a_cone_after_busy, clk, rst, $rose(out_valid), $past(!(in_valid && in_ready)))
  `CCB_ASSERT_SAME(a_energy_order, clk, rst, out_valid, total_energy > deposited_energy)
  `CCB_ASSERT_SAME(a_axis_nonzero, clk, rst, out_valid, |{axis_x, axis_y, axis_z})
  `CCB_ASSERT_SAME(a_cos_above_minus_one, clk, rst, out_valid, cos_half_angle != COS_MINUS_ONE)
  `CCB_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)

endmodule

bind compton_cone_builder_core ccb_checker u_ccb_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (pulse_in.valid),
  .in_ready         (pulse_in.ready),
  .out_valid        (cone_out.valid),
  .out_ready        (cone_out.ready),
  .axis_x           (cone_out.axis_x),
  .axis_y           (cone_out.axis_y),
  .axis_z           (cone_out.axis_z),
  .cos_half_angle   (cone_out.cos_half_angle),
  .total_energy     (cone_out.total_energy),
  .deposited_energy (cone_out.deposited_energy)
);

### verif/compton_cone_builder_core_test.sv
// Self-checking testbench for compton_cone_builder_core: pulses go in, predicted cones are
// compared field by field with the transfers on the cone channel, under random stalls.
// Depends on ccb_pkg, ccb_pulse_if, ccb_cone_if and the core itself.
module compton_cone_builder_core_test;
  import ccb_pkg::*;

  localparam int BUSY_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

  typedef struct {
    logic [HIST_W-1:0]   history;
    logic [ENERGY_W-1:0] initial_energy;
    logic [ENERGY_W-1:0] pulse_height;
    pos_t                pos[3];
  } pulse_t;

  typedef struct {
    pos_t                    apex_x;
    pos_t                    apex_y;
    pos_t                    apex_z;
    axis_t                   axis_x;
    axis_t                   axis_y;
    axis_t                   axis_z;
    logic signed [COS_W-1:0] cos_half_angle;
    logic [ENERGY_W-1:0]     total_energy;
    logic [ENERGY_W-1:0]     deposited_energy;
    logic [HIST_W-1:0]       cone_history;
  } cone_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccb_pulse_if pulse_ch();
  ccb_cone_if cone_ch();

  compton_cone_builder_core uut (
    .clk(clk),
    .rst(rst),
    .pulse_in(pulse_ch),
    .cone_out(cone_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [ENERGY_W-1:0] peak_setting = PEAK_RESET;
  logic [ENERGY_W-1:0] window_setting = WINDOW_RESET;
  logic [HIST_W-1:0] group_history = '0;
  logic [1:0] group_size = COUNT_NONE;
  logic [ENERGY_W-1:0] lead_energy = '0;
  logic [ENERGY_W-1:0] lead_height = '0;
  logic [ENERGY_W-1:0] runner_energy = '0;
  pos_t lead_pos[3] = '{default: '0};
  pos_t runner_pos[3] = '{default: '0};

  cone_t pending_cones[$];
  cone_t oldest;
  int fail_count = 0;
  int unsigned cycle_count = 0;
  bit idling = 1'b1;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit cone_from_group(output cone_t c);
    longint unsigned e, h, den, num, scaled, ratio;
    longint dev;
    int diff[3];
    c = '{default: '0};
    if (group_size != COUNT_MANY) return 1'b0;
    e = lead_energy;
    h = lead_height;
    dev = longint'(e) - longint'(peak_setting);
    if (dev < 0) dev = -dev;
    if (dev > longint'(window_setting)) return 1'b0;
    if (h == 0 || e <= h) return 1'b0;
    den = e * (e - h);
    num = h * ELECTRON_MASS;
    if (num >= 2 * den) return 1'b0;
    scaled = num << 16;
    ratio = scaled / den;
    // A positive cosine truncates toward zero, so the subtracted ratio rounds up.
    if (num < den && scaled % den != 0) ratio++;
    for (int k = 0; k < 3; k++) diff[k] = int'(runner_pos[k]) - int'(lead_pos[k]);
    if (diff[0] == 0 && diff[1] == 0 && diff[2] == 0) return 1'b0;
    c.apex_x = lead_pos[0];
    c.apex_y = lead_pos[1];
    c.apex_z = lead_pos[2];
    c.axis_x = AXIS_W'(diff[0]);
    c.axis_y = AXIS_W'(diff[1]);
    c.axis_z = AXIS_W'(diff[2]);
    c.cos_half_angle = COS_W'(longint'(Q16_ONE) - longint'(ratio));
    c.total_energy = lead_energy;
    c.deposited_energy = lead_height;
    c.cone_history = group_history;
    return 1'b1;
  endfunction

  function automatic void track_pulse(input pulse_t p);
    cone_t c;
    if (group_size != COUNT_NONE && p.history != group_history) begin
      if (cone_from_group(c)) pending_cones = {pending_cones, c};
      group_size = COUNT_NONE;
    end
    group_history = p.history;
    if (group_size == COUNT_NONE) begin
      lead_energy = p.initial_energy;
      lead_height = p.pulse_height;
      lead_pos = p.pos;
      group_size = COUNT_ONE;
    end else begin
      if (p.initial_energy > lead_energy) begin
        runner_energy = lead_energy;
        runner_pos = lead_pos;
        lead_energy = p.initial_energy;
        lead_height = p.pulse_height;
        lead_pos = p.pos;
      end else if (group_size == COUNT_ONE || p.initial_energy > runner_energy) begin
        runner_energy = p.initial_energy;
        runner_pos = p.pos;
      end
      group_size = COUNT_MANY;
    end
  endfunction

  task automatic send_pulse(input logic [HIST_W-1:0] hist, input logic [ENERGY_W-1:0] energy,
                            input logic [ENERGY_W-1:0] height, input pos_t x, y, z);
    pulse_t p;
    if (idling && $urandom_range(0, 3) == 0) begin
      pulse_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    p.history = hist;
    p.initial_energy = energy;
    p.pulse_height = height;
    p.pos = '{x, y, z};
    pulse_ch.valid = 1'b1;
    pulse_ch.history = hist;
    pulse_ch.initial_energy = energy;
    pulse_ch.pulse_height = height;
    pulse_ch.pos_x = x;
    pulse_ch.pos_y = y;
    pulse_ch.pos_z = z;
    do @(posedge clk); while (pulse_ch.ready !== 1'b1);
    track_pulse(p);
    @(negedge clk);
  endtask

  task automatic drain;
    pulse_ch.valid = 1'b0;
    while (pending_cones.size() != 0) @(negedge clk);
    repeat (BUSY_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [ENERGY_W-1:0] peak, window);
    cfg_we = 1'b1;
    cfg_index = REG_PEAK_ENERGY;
    cfg_data = peak;
    @(negedge clk);
    cfg_index = REG_ENERGY_WINDOW;
    cfg_data = window;
    @(negedge clk);
    cfg_index = REG_UNUSED_A;
    cfg_data = CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_index = REG_UNUSED_B;
    cfg_data = CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we = 1'b0;
    peak_setting = peak;
    window_setting = window;
  endtask

  task automatic random_groups(input int count);
    logic [HIST_W-1:0] hist;
    logic [ENERGY_W-1:0] energy, height, last_energy;
    pos_t x, y, z;
    longint lo, hi;
    int size;
    hist = $urandom;
    last_energy = '0;
    lo = longint'(peak_setting) - longint'(window_setting) - 16;
    hi = longint'(peak_setting) + longint'(window_setting) + 16;
    if (lo < 0) lo = 0;
    if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
    while (count > 0) begin
      hist = ($urandom_range(0, 4) == 0) ? $urandom : hist + 1;
      size = $urandom_range(1, 4);
      for (int k = 0; k < size && count > 0; k++) begin
        if (k > 0 && $urandom_range(0, 3) == 0) energy = last_energy;
        else energy = ENERGY_W'($urandom_range(32'(hi), 32'(lo)));
        case ($urandom_range(0, 19))
          0: height = '0;
          1: height = energy;
          2: height = ENERGY_W'($urandom);
          default: height = (energy > 1) ?
                            ENERGY_W'($urandom_range(32'(energy) - 32'd1, 1)) : '0;
        endcase
        if (k == 0 || $urandom_range(0, 7) != 0) begin
          if ($urandom_range(0, 3) == 0) begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
            z = POS_W'($urandom);
          end else begin
            x = POS_W'($urandom_range(400) - 200);
            y = POS_W'($urandom_range(400) - 200);
            z = POS_W'($urandom_range(400) - 200);
          end
        end
        if ($urandom_range(0, 9) == 0)
          send_pulse($urandom, ENERGY_W'($urandom), ENERGY_W'($urandom),
                     POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        else
          send_pulse(hist, energy, height, x, y, z);
        last_energy = energy;
        count--;
      end
    end
  endtask

  task automatic test_cone_geometry;
    send_pulse(0, 43319, 20000, -32768, 32767, -32768);
    send_pulse(0, 43000, 1000, 32767, -32768, 32767);
    send_pulse(1, 46596, 25000, 10, 20, 30);
    send_pulse(1, 46596, 5, 10, 20, 31);
    send_pulse(1, 100, 1, 0, 0, 0);
  endtask

  task automatic test_ranking;
    send_pulse(2, 40000, 10000, 1, 1, 1);
    send_pulse(2, 44000, 12000, 5, 5, 5);
    send_pulse(2, 42000, 3, 9, 9, 9);
    send_pulse(2, 42000, 7, -9, -9, -9);
  endtask

  task automatic test_rejections;
    send_pulse(3, 43319, 43319, 0, 0, 0);
    send_pulse(4, 43319, 0, 1, 0, 0);
    send_pulse(4, 1000, 0, 2, 0, 0);
    send_pulse(5, 43319, 43319, 0, 0, 0);
    send_pulse(5, 10, 1, 1, 1, 1);
    send_pulse(6, 43319, 50000, 0, 0, 0);
    send_pulse(6, 10, 1, 1, 1, 1);
    send_pulse(7, 43319, 40000, 0, 0, 0);
    send_pulse(7, 10, 1, 1, 1, 1);
    send_pulse(8, 43319, 20000, 7, 7, 7);
    send_pulse(8, 100, 1, 7, 7, 7);
    send_pulse(9, 46597, 1000, 0, 0, 0);
    send_pulse(9, 100, 1, 1, 0, 0);
    send_pulse(10, 40042, 20000, 3, -3, 3);
    send_pulse(10, 100, 1, 0, 0, 0);
    send_pulse(11, 43319, 30000, 0, 0, 0);
    send_pulse(11, 5, 1, -2, 4, 6);
    send_pulse(32'hFFFFFFFF, 24'hFFFFFF, 1, 32767, 32767, 32767);
    send_pulse(32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, -32768, -32768, -32768);
  endtask

  task automatic test_register_extremes;
    drain();
    configure(24'hFFFFFF, 24'h0);
    send_pulse(0, 0, 0, 0, 0, 0);
    drain();
    configure(24'h0, 24'h0);
    send_pulse(0, 0, 0, 1, 1, 1);
    send_pulse(1, 0, 0, 2, 2, 2);
  endtask

  task automatic test_random_nominal;
    drain();
    configure(PEAK_RESET, WINDOW_RESET);
    random_groups(350);
  endtask

  task automatic test_random_wide_window;
    drain();
    idling = 1'b0;
    configure(ENERGY_W'($urandom), 24'hFFFFFF);
    random_groups(250);
  endtask

  task automatic test_random_narrow_window;
    drain();
    idling = 1'b1;
    configure(ENERGY_W'($urandom), ENERGY_W'($urandom_range(0, 4095)));
    random_groups(200);
  endtask

  task automatic test_random_full_rate;
    drain();
    idling = 1'b0;
    configure(PEAK_RESET, WINDOW_RESET);
    random_groups(300);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && cone_ch.valid === 1'b1 && cone_ch.ready === 1'b1) begin
      if (pending_cones.size() == 0) begin
        $error("cone transfer with none expected, history %0d", cone_ch.cone_history);
        fail_count++;
      end else begin
        oldest = pending_cones.pop_front();
        check_field("apex_x", oldest.apex_x, cone_ch.apex_x);
        check_field("apex_y", oldest.apex_y, cone_ch.apex_y);
        check_field("apex_z", oldest.apex_z, cone_ch.apex_z);
        check_field("axis_x", oldest.axis_x, cone_ch.axis_x);
        check_field("axis_y", oldest.axis_y, cone_ch.axis_y);
        check_field("axis_z", oldest.axis_z, cone_ch.axis_z);
        check_field("cos_half_angle", oldest.cos_half_angle, cone_ch.cos_half_angle);
        check_field("total_energy", oldest.total_energy, cone_ch.total_energy);
        check_field("deposited_energy", oldest.deposited_energy, cone_ch.deposited_energy);
        check_field("cone_history", oldest.cone_history, cone_ch.cone_history);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : cone_sink
    int stall;
    stall = 0;
    cone_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && idling && $urandom_range(0, 15) == 0) stall = $urandom_range(1, 14);
      cone_ch.ready = (stall == 0);
      if (stall > 0) stall--;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_PEAK_ENERGY;
    cfg_data = '0;
    pulse_ch.valid = 1'b0;
    pulse_ch.history = '0;
    pulse_ch.initial_energy = '0;
    pulse_ch.pulse_height = '0;
    pulse_ch.pos_x = '0;
    pulse_ch.pos_y = '0;
    pulse_ch.pos_z = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_cone_geometry();
    test_ranking();
    test_rejections();
    test_register_extremes();
    test_random_nominal();
    test_random_wide_window();
    test_random_narrow_window();
    test_random_full_rate();
    pulse_ch.valid = 1'b0;
    while (pending_cones.size() != 0) @(posedge clk);
    repeat (BUSY_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_cones.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ccb_pkg.sv
hw/rtl/ccb_pulse_if.sv
hw/rtl/ccb_cone_if.sv
hw/rtl/compton_cone_builder_core.sv
hw/rtl/ccb_checker.sv
verif/compton_cone_builder_core_test.sv
